[rtl/core/gsmd_pkg.sv]
// ----------------------------------------------------------------------------
// gsmd_pkg: shared types and constants of the gamepad slot mapper
// Holds the slot count, command codes, key table and the request, result,
// configuration and slot entry records used across the block.
// ----------------------------------------------------------------------------
package gsmd_pkg;

  // Slot table size and derived index width
  localparam int SLOTS  = 4;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int NKEYS  = 13;
  localparam int AXIS_W = 16;
  localparam int NAXES  = 6;

  // Axis positions inside a slot entry
  localparam logic [2:0] AXIS_LX = 3'd0;
  localparam logic [2:0] AXIS_LY = 3'd1;
  localparam logic [2:0] AXIS_RX = 3'd2;
  localparam logic [2:0] AXIS_RY = 3'd3;
  localparam logic [2:0] AXIS_LT = 3'd4;
  localparam logic [2:0] AXIS_RT = 3'd5;

  // The shaper handles the four stick axes, tagged by axis position
  localparam int TAG_W = 2;
  localparam logic [TAG_W-1:0] TAG_LAST = 2'd3;

  // Command codes
  typedef enum logic [2:0] {
    CMD_KEY    = 3'd0,
    CMD_AXES   = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_SAMPLE = 3'd4
  } cmd_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEADZONE = 2'd0;
  localparam logic [1:0] CFG_GAIN     = 2'd1;
  localparam logic [1:0] CFG_THRESH   = 2'd2;

  localparam logic [14:0] DEADZONE_RST = 15'd4588;
  localparam logic [15:0] GAIN_RST     = 16'd19051;
  localparam logic [14:0] THRESH_RST   = 15'd16384;

  // Buttons with analog sources
  localparam logic [15:0] BTN_Z      = 16'h2000;
  localparam logic [15:0] BTN_CUP    = 16'h0008;
  localparam logic [15:0] BTN_CDOWN  = 16'h0004;
  localparam logic [15:0] BTN_CLEFT  = 16'h0002;
  localparam logic [15:0] BTN_CRIGHT = 16'h0001;

  // Mapped key codes and the console button each one drives
  localparam logic [8:0] KEY_CODES [NKEYS] = '{
    9'd19, 9'd20, 9'd21, 9'd22, 9'd96, 9'd97, 9'd99, 9'd100,
    9'd102, 9'd103, 9'd104, 9'd105, 9'd108
  };
  localparam logic [15:0] KEY_MASKS [NKEYS] = '{
    16'h0800, 16'h0400, 16'h0200, 16'h0100, 16'h8000, 16'h0001, 16'h4000,
    16'h0008, 16'h0020, 16'h0010, 16'h2000, 16'h0004, 16'h1000
  };

  typedef struct packed {
    logic [14:0] deadzone;
    logic [15:0] gain;
    logic [14:0] thresh;
  } cfg_t;

  typedef struct packed {
    logic [2:0]               cmd;
    logic [15:0]              dev_id;
    logic [8:0]               key_code;
    logic                     pressed;
    logic signed [AXIS_W-1:0] left_x;
    logic signed [AXIS_W-1:0] left_y;
    logic signed [AXIS_W-1:0] right_x;
    logic signed [AXIS_W-1:0] right_y;
    logic signed [AXIS_W-1:0] left_trig;
    logic signed [AXIS_W-1:0] right_trig;
    logic [2:0]               player;
  } req_t;

  typedef struct packed {
    logic [15:0]              buttons;
    logic signed [AXIS_W-1:0] stick_x;
    logic signed [AXIS_W-1:0] stick_y;
  } res_t;

  // One slot entry of the slot memory
  typedef struct packed {
    logic [NKEYS-1:0]             keys;
    logic [NAXES-1:0][AXIS_W-1:0] axes;
  } entry_t;

  // Map a key code to its held-key bit, all zero for an unmapped code
  function automatic logic [NKEYS-1:0] key_bit(input logic [8:0] code);
    logic [NKEYS-1:0] m;
    m = '0;
    for (int k = 0; k < NKEYS; k++) begin
      if (KEY_CODES[k] == code) begin
        m[k] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

[rtl/core/gsmd_shape.sv]
// ----------------------------------------------------------------------------
// gsmd_shape: deadzone shaper for stick axes
// Two-stage pipeline: magnitude and deadzone subtract, then gain multiply,
// saturate to 32767 and restore the sign. One axis enters per cycle.
// ----------------------------------------------------------------------------
module gsmd_shape (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gsmd_pkg::cfg_t                   cfg_i,
  input  logic                             in_valid_i,
  input  logic [gsmd_pkg::TAG_W-1:0]       in_tag_i,
  input  logic signed [gsmd_pkg::AXIS_W-1:0] in_value_i,
  output logic                             out_valid_o,
  output logic [gsmd_pkg::TAG_W-1:0]       out_tag_o,
  output logic signed [gsmd_pkg::AXIS_W-1:0] out_value_o
);
  import gsmd_pkg::*;

  logic [AXIS_W-1:0] mag;
  logic              over;
  logic [AXIS_W-1:0] diff_d, diff_q;
  logic              neg_q, over_q, v1_q, v2_q;
  logic [TAG_W-1:0]  tag1_q, tag2_q;
  logic [31:0]       prod;
  logic [14:0]       sat;
  logic [AXIS_W-1:0] res_d;
  logic signed [AXIS_W-1:0] res_q;

  // Stage one: absolute value and distance past the deadzone
  always_comb begin
    mag    = in_value_i[AXIS_W-1] ? (~in_value_i + 16'd1) : in_value_i;
    over   = mag > {1'b0, cfg_i.deadzone};
    diff_d = mag - {1'b0, cfg_i.deadzone};
  end

  // Stage two: rescale in Q2.14, saturate and apply the sign
  always_comb begin
    prod  = 32'(diff_q) * 32'(cfg_i.gain);
    sat   = (|prod[31:29]) ? 15'h7FFF : prod[28:14];
    if (!over_q) begin
      res_d = '0;
    end else if (neg_q) begin
      res_d = 16'd0 - {1'b0, sat};
    end else begin
      res_d = {1'b0, sat};
    end
  end

  // Advance the valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  // Hold the pipeline payload
  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    neg_q  <= in_value_i[AXIS_W-1];
    over_q <= over;
    tag1_q <= in_tag_i;
    tag2_q <= tag1_q;
    res_q  <= res_d;
  end

  assign out_valid_o = v2_q;
  assign out_tag_o   = tag2_q;
  assign out_value_o = res_q;

endmodule

[rtl/core/gsmd_engine.sv]
// ----------------------------------------------------------------------------
// gsmd_engine: slot lookup, slot memory and command sequencer
// Matches the device against the slot tags, reads the slot entry from a
// synchronous memory, modifies and writes it back, and builds the sample
// result through the shared shaper.
// ----------------------------------------------------------------------------
module gsmd_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gsmd_pkg::cfg_t  cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  gsmd_pkg::req_t  req_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output gsmd_pkg::res_t  res_o
);
  import gsmd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_SHAPE, ST_DRAIN, ST_BTN, ST_DONE
  } state_e;

  state_e             state_q;
  logic [SLOTS-1:0]   used_q;
  logic [15:0]        dev_q [SLOTS];
  entry_t             mem_q [SLOTS];
  entry_t             rd_q;
  req_t               req_q;
  logic [SLOT_W-1:0]  slot_q;
  logic               act_q, fresh_q;
  logic [TAG_W-1:0]   cnt_q;
  logic signed [AXIS_W-1:0] sh_q [4];
  res_t               res_q;

  logic               accept;
  logic               hit_any, free_any;
  logic [SLOT_W-1:0]  hit_idx, free_idx;
  logic               player_ok;
  logic [SLOT_W-1:0]  player_slot;
  logic [SLOT_W-1:0]  sel_slot;
  logic               sel_act, sel_fresh;
  entry_t             cur, wr_entry;
  logic               mem_we;
  logic [NKEYS-1:0]   kbit;
  logic               sh_out_valid;
  logic [TAG_W-1:0]   sh_out_tag;
  logic signed [AXIS_W-1:0] sh_out_value;
  logic [15:0]        btn;
  logic signed [16:0] thr17, nthr17, rx17, ry17, lt17, rt17;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  // Match the device against the slot tags and find the lowest free slot
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (used_q[i] && (dev_q[i] == req_i.dev_id)) begin
        hit_any = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!used_q[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign player_ok   = ({2'b00, req_i.player} < 5'(SLOTS));
  assign player_slot = SLOT_W'(req_i.player);

  // Choose the slot that the request works on
  always_comb begin
    sel_slot  = '0;
    sel_act   = 1'b0;
    sel_fresh = 1'b0;
    unique case (req_i.cmd) inside
      CMD_KEY, CMD_AXES: begin
        sel_act   = hit_any || free_any;
        sel_slot  = hit_any ? hit_idx : free_idx;
        sel_fresh = !hit_any;
      end
      CMD_REMOVE: begin
        sel_act  = hit_any;
        sel_slot = hit_idx;
      end
      CMD_SAMPLE: begin
        sel_slot = player_slot;
        sel_act  = player_ok && used_q[player_slot];
      end
      default: begin
        sel_act = 1'b0;
      end
    endcase
  end

  // A freshly claimed slot starts from a cleared entry
  always_comb begin
    cur      = fresh_q ? '0 : rd_q;
    wr_entry = cur;
    kbit     = key_bit(req_q.key_code);
    if (req_q.cmd == CMD_KEY) begin
      wr_entry.keys = req_q.pressed ? (cur.keys | kbit) : (cur.keys & ~kbit);
    end else begin
      wr_entry.axes[AXIS_LX] = req_q.left_x;
      wr_entry.axes[AXIS_LY] = req_q.left_y;
      wr_entry.axes[AXIS_RX] = req_q.right_x;
      wr_entry.axes[AXIS_RY] = req_q.right_y;
      wr_entry.axes[AXIS_LT] = req_q.left_trig[AXIS_W-1] ? '0 : req_q.left_trig;
      wr_entry.axes[AXIS_RT] = req_q.right_trig[AXIS_W-1] ? '0 : req_q.right_trig;
    end
  end

  assign mem_we = (state_q == ST_EXEC) && act_q &&
                  ((req_q.cmd == CMD_KEY) || (req_q.cmd == CMD_AXES));

  // Slot memory: read on accept, write back in the following cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[slot_q] <= wr_entry;
      dev_q[slot_q] <= req_q.dev_id;
    end
    if (accept) begin
      rd_q   <= mem_q[sel_slot];
      req_q  <= req_i;
      slot_q <= sel_slot;
    end
    if (sh_out_valid) begin
      sh_q[sh_out_tag] <= sh_out_value;
    end
  end

  // Shared shaper, fed one stick axis per cycle
  gsmd_shape u_shape (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .in_valid_i  (state_q == ST_SHAPE),
    .in_tag_i    (cnt_q),
    .in_value_i  (rd_q.axes[{1'b0, cnt_q}]),
    .out_valid_o (sh_out_valid),
    .out_tag_o   (sh_out_tag),
    .out_value_o (sh_out_value)
  );

  // Build the console button word from held keys and analog levels
  always_comb begin
    thr17  = {2'b00, cfg_i.thresh};
    nthr17 = 17'sd0 - thr17;
    rx17   = {sh_q[TAG_W'(AXIS_RX)][AXIS_W-1], sh_q[TAG_W'(AXIS_RX)]};
    ry17   = {sh_q[TAG_W'(AXIS_RY)][AXIS_W-1], sh_q[TAG_W'(AXIS_RY)]};
    lt17   = {rd_q.axes[AXIS_LT][AXIS_W-1], rd_q.axes[AXIS_LT]};
    rt17   = {rd_q.axes[AXIS_RT][AXIS_W-1], rd_q.axes[AXIS_RT]};
    btn    = '0;
    for (int k = 0; k < NKEYS; k++) begin
      if (rd_q.keys[k]) begin
        btn = btn | KEY_MASKS[k];
      end
    end
    if (lt17 > thr17)  btn = btn | BTN_Z;
    if (rt17 > thr17)  btn = btn | BTN_CDOWN;
    if (ry17 < nthr17) btn = btn | BTN_CUP;
    if (ry17 > thr17)  btn = btn | BTN_CDOWN;
    if (rx17 < nthr17) btn = btn | BTN_CLEFT;
    if (rx17 > thr17)  btn = btn | BTN_CRIGHT;
  end

  // Sequencer with slot flags and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      used_q  <= '0;
      act_q   <= 1'b0;
      fresh_q <= 1'b0;
      cnt_q   <= '0;
      res_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            act_q   <= sel_act;
            fresh_q <= sel_fresh;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q <= ST_IDLE;
          unique case (req_q.cmd) inside
            CMD_KEY, CMD_AXES: begin
              if (act_q) used_q[slot_q] <= 1'b1;
            end
            CMD_REMOVE: begin
              if (act_q) used_q[slot_q] <= 1'b0;
            end
            CMD_CLEAR: begin
              used_q <= '0;
            end
            CMD_SAMPLE: begin
              if (act_q) begin
                cnt_q   <= '0;
                state_q <= ST_SHAPE;
              end else begin
                res_q   <= '0;
                state_q <= ST_DONE;
              end
            end
            default: begin
              state_q <= ST_IDLE;
            end
          endcase
        end
        ST_SHAPE: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == TAG_LAST) state_q <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (sh_out_valid && (sh_out_tag == TAG_LAST)) state_q <= ST_BTN;
        end
        ST_BTN: begin
          res_q.buttons <= btn;
          res_q.stick_x <= sh_q[TAG_W'(AXIS_LX)];
          res_q.stick_y <= 16'sd0 - sh_q[TAG_W'(AXIS_LY)];
          state_q       <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready_i) state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

endmodule

[rtl/core/gamepad_slot_mapper_with_deadzone.sv]
// ----------------------------------------------------------------------------
// gamepad_slot_mapper_with_deadzone: gamepad slot table with stick shaping
// Key and axes requests update the slot owning a device, remove and clear
// free slots, and a sample request returns the button word and left stick.
//
//   channel  dir  handshake                     payload
//   s_axis   in   s_axis_tvalid_i/tready_o      tuser cmd, tdata request
//   m_axis   out  m_axis_tvalid_o/tready_i      tdata result
//   cfg      in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// Key, axes, remove, clear and ignored commands match the slot tags and read
// the slot memory, then write the entry back or update the slot flags.
// A sample feeds the four stick axes in turn through the single shaper.
// The output register lets a new request in while a result waits; a sample
// waits only when that register is still full. Reset frees every slot at once.
// ----------------------------------------------------------------------------
module gamepad_slot_mapper_with_deadzone (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // dev_id[15:0], key_code[24:16], pressed[25], left_x[41:26],
  // left_y[57:42], right_x[73:58], right_y[89:74], left_trig[105:90],
  // right_trig[121:106], player[124:122], zero[127:125]
  input  logic [127:0] s_axis_tdata_i,
  // cmd[2:0]
  input  logic [2:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // buttons[15:0], stick_x[31:16], stick_y[47:32]
  output logic [47:0]  m_axis_tdata_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);
  import gsmd_pkg::*;

  cfg_t  cfg_q;
  req_t  req;
  res_t  res;
  logic  res_valid, res_ready;
  logic  out_valid_q;
  res_t  out_q;

  // Unpack the request
  always_comb begin
    req.cmd        = s_axis_tuser_i;
    req.dev_id     = s_axis_tdata_i[15:0];
    req.key_code   = s_axis_tdata_i[24:16];
    req.pressed    = s_axis_tdata_i[25];
    req.left_x     = s_axis_tdata_i[41:26];
    req.left_y     = s_axis_tdata_i[57:42];
    req.right_x    = s_axis_tdata_i[73:58];
    req.right_y    = s_axis_tdata_i[89:74];
    req.left_trig  = s_axis_tdata_i[105:90];
    req.right_trig = s_axis_tdata_i[121:106];
    req.player     = s_axis_tdata_i[124:122];
  end

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadzone <= DEADZONE_RST;
      cfg_q.gain     <= GAIN_RST;
      cfg_q.thresh   <= THRESH_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEADZONE: cfg_q.deadzone <= cfg_data_i[14:0];
        CFG_GAIN:     cfg_q.gain     <= cfg_data_i;
        CFG_THRESH:   cfg_q.thresh   <= cfg_data_i[14:0];
        default:      cfg_q          <= cfg_q;
      endcase
    end
  end

  gsmd_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: take a result whenever empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.stick_y, out_q.stick_x, out_q.buttons};

endmodule

[sim/gamepad_slot_mapper_with_deadzone_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gamepad_slot_mapper_with_deadzone_test: self-checking bench for the mapper
// Drives key, axes, remove, clear, sample and unused requests. A slot table
// model in the bench predicts every sample result, which is checked field by
// field. Covers a full table, unknown devices, deadzone and saturation
// corners, several register settings, random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module gamepad_slot_mapper_with_deadzone_test;
  import gsmd_pkg::*;

  // Command codes that the block must ignore
  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;
  // Register index with no register behind it
  localparam logic [1:0] CFG_SPARE = 2'd3;

  localparam int DRAIN_CYCLES = 24;
  localparam int PHASE_ITEMS  = 100;

  // Mapped key codes and their console buttons, entry 0 in the lowest bits
  localparam logic [12:0][8:0] KEY_CODE_MAP = {
    9'd108, 9'd105, 9'd104, 9'd103, 9'd102, 9'd100, 9'd99, 9'd97, 9'd96,
    9'd22, 9'd21, 9'd20, 9'd19
  };
  localparam logic [12:0][15:0] KEY_BTN_MAP = {
    16'h1000, 16'h0004, 16'h2000, 16'h0010, 16'h0020, 16'h0008, 16'h4000,
    16'h0001, 16'h8000, 16'h0100, 16'h0200, 16'h0400, 16'h0800
  };

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [127:0] s_axis_tdata_i = '0;
  logic [2:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [47:0]  m_axis_tdata_o;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [15:0]  cfg_data_i = '0;

  gamepad_slot_mapper_with_deadzone dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Slot table and register copies kept by the bench
  logic                pad_used [SLOTS];
  logic [15:0]         pad_dev  [SLOTS];
  logic [12:0]         pad_keys [SLOTS];
  logic signed [15:0]  pad_axes [SLOTS][NAXES];
  logic [14:0]         pad_deadzone = DEADZONE_RST;
  logic [15:0]         pad_gain     = GAIN_RST;
  logic [14:0]         pad_thresh   = THRESH_RST;

  res_t        samples_due [$];
  req_t        request_q [$];
  req_t        pending_req;
  logic [15:0] dev_pool [6];

  int requests_sent  = 0;
  int requests_taken = 0;
  int samples_seen   = 0;
  int reg_writes     = 0;
  int fail_count     = 0;

  // Sender and receiver pacing
  bit tx_gaps_on    = 1'b1;
  int tx_burst_left = 0;
  int tx_gap_left   = 0;
  bit rx_stalls_on  = 1'b1;
  bit rx_level      = 1'b1;
  int rx_run_left   = 0;
  int rx_hold_left  = 0;

  // ---------------------------------------------------------------- predictor

  function automatic void free_slot(input int s);
    pad_used[s] = 1'b0;
    pad_dev[s]  = '0;
    pad_keys[s] = '0;
    for (int k = 0; k < NAXES; k++) begin
      pad_axes[s][k] = '0;
    end
  endfunction

  // Find the slot owning a device; optionally claim the lowest free one
  function automatic int locate_slot(input logic [15:0] dev, input bit claim);
    for (int i = 0; i < SLOTS; i++) begin
      if (pad_used[i] && pad_dev[i] == dev) return i;
    end
    if (!claim) return -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!pad_used[i]) begin
        free_slot(i);
        pad_used[i] = 1'b1;
        pad_dev[i]  = dev;
        return i;
      end
    end
    return -1;
  endfunction

  // Deadzone cut, gain and saturation of one stick level
  function automatic int shape_level(input logic signed [15:0] v);
    int     m;
    longint r;
    m = v;
    if (m < 0) m = -m;
    if (m <= int'(pad_deadzone)) return 0;
    r = (longint'(m - int'(pad_deadzone)) * longint'(pad_gain)) >> 14;
    if (r > 32767) r = 32767;
    return (v < 0) ? -int'(r) : int'(r);
  endfunction

  function automatic res_t sample_pad(input logic [2:0] player);
    res_t o;
    int   th;
    int   rx;
    int   ry;
    o = '0;
    if (player < SLOTS && pad_used[player]) begin
      th = int'(pad_thresh);
      rx = shape_level(pad_axes[player][AXIS_RX]);
      ry = shape_level(pad_axes[player][AXIS_RY]);
      for (int k = 0; k < NKEYS; k++) begin
        if (pad_keys[player][k]) o.buttons |= KEY_BTN_MAP[k];
      end
      if (int'(pad_axes[player][AXIS_LT]) > th) o.buttons |= BTN_Z;
      if (int'(pad_axes[player][AXIS_RT]) > th) o.buttons |= BTN_CDOWN;
      if (ry < -th) o.buttons |= BTN_CUP;
      if (ry > th)  o.buttons |= BTN_CDOWN;
      if (rx < -th) o.buttons |= BTN_CLEFT;
      if (rx > th)  o.buttons |= BTN_CRIGHT;
      o.stick_x = 16'(shape_level(pad_axes[player][AXIS_LX]));
      o.stick_y = 16'(-shape_level(pad_axes[player][AXIS_LY]));
    end
    return o;
  endfunction

  // Apply one accepted request to the table, queue the result of a sample
  function automatic void update_slot_table(input req_t r);
    int s;
    case (r.cmd)
      CMD_KEY: begin
        s = locate_slot(r.dev_id, 1'b1);
        if (s >= 0) begin
          for (int k = 0; k < NKEYS; k++) begin
            if (KEY_CODE_MAP[k] == r.key_code) pad_keys[s][k] = r.pressed;
          end
        end
      end
      CMD_AXES: begin
        s = locate_slot(r.dev_id, 1'b1);
        if (s >= 0) begin
          pad_axes[s][AXIS_LX] = r.left_x;
          pad_axes[s][AXIS_LY] = r.left_y;
          pad_axes[s][AXIS_RX] = r.right_x;
          pad_axes[s][AXIS_RY] = r.right_y;
          pad_axes[s][AXIS_LT] = r.left_trig[15] ? 16'sd0 : r.left_trig;
          pad_axes[s][AXIS_RT] = r.right_trig[15] ? 16'sd0 : r.right_trig;
        end
      end
      CMD_REMOVE: begin
        s = locate_slot(r.dev_id, 1'b0);
        if (s >= 0) free_slot(s);
      end
      CMD_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) free_slot(i);
      end
      CMD_SAMPLE: samples_due.push_back(sample_pad(r.player));
      default: ;
    endcase
  endfunction

  function automatic logic [127:0] pack_request(input req_t r);
    return {3'b000, r.player, r.right_trig, r.left_trig, r.right_y, r.right_x,
            r.left_y, r.left_x, r.pressed, r.key_code, r.dev_id};
  endfunction

  initial begin
    for (int i = 0; i < SLOTS; i++) free_slot(i);
  end

  // ---------------------------------------------------------------- sender

  // Present queued requests in bursts; predict each one as it is taken
  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      update_slot_table(pending_req);
      requests_taken++;
    end
    if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (tx_gap_left > 0) begin
        tx_gap_left--;
        s_axis_tvalid_i <= 1'b0;
      end else if (rst_ni && request_q.size() > 0) begin
        pending_req = request_q.pop_front();
        s_axis_tdata_i  <= pack_request(pending_req);
        s_axis_tuser_i  <= pending_req.cmd;
        s_axis_tvalid_i <= 1'b1;
        if (tx_burst_left > 0) begin
          tx_burst_left--;
        end else if (tx_gaps_on) begin
          tx_burst_left = $urandom_range(0, 11);
          tx_gap_left   = $urandom_range(1, 6);
        end
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  // Hold off on request, else stall in runs of random length
  always @(posedge clk_i) begin
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (!rx_stalls_on) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      if (rx_run_left == 0) begin
        rx_level    = !rx_level;
        rx_run_left = rx_level ? $urandom_range(1, 8) : $urandom_range(1, 5);
      end else begin
        rx_run_left--;
      end
      m_axis_tready_i <= rx_level;
    end
  end

  // ---------------------------------------------------------------- checker

  task automatic report_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] seen);
    fail_count++;
    if (fail_count <= 40) begin
      $display("%0t: sample %0d %s: expected %h, got %h",
               $realtime, samples_seen, what, want, seen);
    end
  endtask

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.buttons = m_axis_tdata_o[15:0];
      got.stick_x = m_axis_tdata_o[31:16];
      got.stick_y = m_axis_tdata_o[47:32];
      if (samples_due.size() == 0) begin
        report_mismatch("result with no sample pending", 16'h0000, got.buttons);
      end else begin
        want = samples_due.pop_front();
        if (got.buttons !== want.buttons)
          report_mismatch("buttons", want.buttons, got.buttons);
        if (got.stick_x !== want.stick_x)
          report_mismatch("stick_x", want.stick_x, got.stick_x);
        if (got.stick_y !== want.stick_y)
          report_mismatch("stick_y", want.stick_y, got.stick_y);
      end
      samples_seen++;
    end
  end

  // ---------------------------------------------------------------- helpers

  task automatic send_request(input req_t r);
    while (request_q.size() >= 2) @(posedge clk_i);
    request_q.push_back(r);
    requests_sent++;
  endtask

  // Wait until every request is taken and every result has come back
  task automatic wait_for_quiet();
    while (requests_taken != requests_sent || samples_due.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [15:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (index)
      CFG_DEADZONE: pad_deadzone = data[14:0];
      CFG_GAIN:     pad_gain     = data;
      CFG_THRESH:   pad_thresh   = data[14:0];
      default: ;
    endcase
    reg_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic req_t noise_request(input logic [2:0] cmd,
                                         input logic [15:0] dev);
    req_t r;
    r = req_t'({$urandom, $urandom, $urandom, $urandom});
    r.cmd    = cmd;
    r.dev_id = dev;
    return r;
  endfunction

  task automatic send_key(input logic [15:0] dev, input logic [8:0] code,
                          input logic down);
    req_t r;
    r = noise_request(CMD_KEY, dev);
    r.key_code = code;
    r.pressed  = down;
    send_request(r);
  endtask

  task automatic send_axes(input logic [15:0] dev,
                           input logic signed [15:0] lx, ly, rx, ry, lt, rt);
    req_t r;
    r = noise_request(CMD_AXES, dev);
    r.left_x     = lx;
    r.left_y     = ly;
    r.right_x    = rx;
    r.right_y    = ry;
    r.left_trig  = lt;
    r.right_trig = rt;
    send_request(r);
  endtask

  task automatic send_sample(input logic [2:0] player);
    req_t r;
    r = noise_request(CMD_SAMPLE, 16'($urandom));
    r.player = player;
    send_request(r);
  endtask

  // Pick levels that favour the deadzone edge, the press edge and the rails
  function automatic logic signed [15:0] random_level();
    int d;
    case ($urandom_range(0, 6))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: d = int'(pad_deadzone) + $urandom_range(0, 2) - 1;
      3: d = int'(pad_thresh) + $urandom_range(0, 2) - 1;
      4: d = $urandom_range(0, 64);
      default: return 16'($urandom);
    endcase
    return 16'($urandom_range(0, 1) ? -d : d);
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   pick;
    r = noise_request(CMD_KEY, ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                         : dev_pool[$urandom_range(0, 5)]);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      if ($urandom_range(0, 4) != 0) r.key_code = KEY_CODE_MAP[$urandom_range(0, NKEYS - 1)];
    end else if (pick < 55) begin
      r.cmd        = CMD_AXES;
      r.left_x     = random_level();
      r.left_y     = random_level();
      r.right_x    = random_level();
      r.right_y    = random_level();
      r.left_trig  = random_level();
      r.right_trig = random_level();
    end else if (pick < 88) begin
      r.cmd    = CMD_SAMPLE;
      r.player = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(SLOTS, 7))
                                             : 3'($urandom_range(0, SLOTS - 1));
    end else if (pick < 95) begin
      r.cmd = CMD_REMOVE;
    end else if (pick < 97) begin
      r.cmd = CMD_CLEAR;
    end else begin
      r.cmd = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
    end
    return r;
  endfunction

  // Six devices compete for the slots, the rail ids now and then
  task automatic refresh_dev_pool();
    for (int i = 0; i < 6; i++) dev_pool[i] = 16'($urandom);
    if ($urandom_range(0, 1)) dev_pool[0] = 16'h0000;
    if ($urandom_range(0, 1)) dev_pool[1] = 16'hFFFF;
  endtask

  // ---------------------------------------------------------------- tests

  // Empty and out-of-range samples, full table, unknown device, ignored codes
  task automatic test_directed();
    send_sample(3'd0);
    send_sample(3'd7);
    send_key(16'hFFFF, 9'd96, 1'b1);
    send_key(16'hFFFF, 9'd511, 1'b1);
    send_key(16'hFFFF, 9'd104, 1'b1);
    send_axes(16'hFFFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
              16'sh7FFF);
    send_sample(3'd0);
    send_key(16'h0000, 9'd19, 1'b1);
    send_axes(16'h0000, 16'sd4588, 16'sd4589, -16'sd4589, 16'sd0, 16'sh7FFF,
              -16'sd1);
    send_key(16'h0002, 9'd108, 1'b1);
    send_key(16'h0003, 9'd22, 1'b1);
    send_key(16'h0004, 9'd20, 1'b1);
    send_axes(16'h0005, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
              16'sh7FFF);
    send_sample(3'd1);
    send_sample(3'd2);
    send_sample(3'd3);
    send_request(noise_request(CMD_REMOVE, 16'h0009));
    send_request(noise_request(CMD_REMOVE, 16'h0000));
    send_key(16'h0004, 9'd20, 1'b1);
    send_sample(3'd1);
    send_key(16'hFFFF, 9'd96, 1'b0);
    send_sample(3'd0);
    send_request(noise_request(CMD_UNUSED_FIRST, 16'hFFFF));
    send_request(noise_request(CMD_UNUSED_LAST, 16'h0000));
    send_request(noise_request(CMD_CLEAR, 16'h0000));
    send_sample(3'd0);
    wait_for_quiet();
  endtask

  // Hold the receiver off long enough that the block must stall its input
  task automatic test_output_backpressure();
    req_t r;
    refresh_dev_pool();
    tx_gaps_on   = 1'b0;
    rx_hold_left = 300;
    for (int i = 0; i < 40; i++) begin
      r = random_request();
      if (i % 2 == 1) begin
        r.cmd    = CMD_SAMPLE;
        r.player = 3'($urandom_range(0, SLOTS - 1));
      end
      send_request(r);
    end
    wait_for_quiet();
    tx_gaps_on = 1'b1;
  endtask

  // Random traffic under reset values, the extremes and random settings
  task automatic test_register_settings();
    for (int phase = 0; phase < 6; phase++) begin
      wait_for_quiet();
      case (phase)
        1: begin
          write_register(CFG_DEADZONE, 16'h0000);
          write_register(CFG_GAIN, 16'hFFFF);
          write_register(CFG_THRESH, 16'h0000);
        end
        2: begin
          write_register(CFG_DEADZONE, 16'h7FFF);
          write_register(CFG_GAIN, 16'h0000);
          write_register(CFG_THRESH, 16'h7FFF);
        end
        3: begin
          // top data bit must be dropped by the 15-bit registers
          write_register(CFG_DEADZONE, 16'h8000 | 16'($urandom_range(0, 8000)));
          write_register(CFG_GAIN, 16'($urandom));
          write_register(CFG_THRESH, 16'h8000 | 16'($urandom));
          write_register(CFG_SPARE, 16'($urandom));
        end
        4: begin
          write_register(CFG_DEADZONE, 16'($urandom_range(0, 6000)));
          write_register(CFG_GAIN, 16'($urandom_range(16384, 49151)));
          write_register(CFG_THRESH, 16'($urandom_range(4096, 28000)));
        end
        5: begin
          write_register(CFG_DEADZONE, 16'(DEADZONE_RST));
          write_register(CFG_GAIN, GAIN_RST);
          write_register(CFG_THRESH, 16'(THRESH_RST));
        end
        default: ;
      endcase
      tx_gaps_on   = (phase != 2 && phase != 5);
      rx_stalls_on = (phase != 1 && phase != 5);
      refresh_dev_pool();
      repeat (PHASE_ITEMS) send_request(random_request());
    end
    wait_for_quiet();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_output_backpressure();
    test_register_settings();
    $display("Ran %0d requests with %0d samples checked and %0d register writes,",
             requests_sent, samples_seen, reg_writes);
    $display("over six register settings with sender gaps and receiver stalls.");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("Timed out with %0d samples outstanding", samples_due.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/gsmd_pkg.sv
rtl/core/gsmd_shape.sv
rtl/core/gsmd_engine.sv
rtl/core/gamepad_slot_mapper_with_deadzone.sv
sim/gamepad_slot_mapper_with_deadzone_test.sv
